// File: design/assert_macros.svh
// Assertion macros shared by the animation channel decoder modules.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define AVCD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define AVCD_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: design/avcd_pkg.sv
// Types, constants and symbol decode functions of the animation channel decoder.
// No dependencies; used by avcd_ctrl, avcd_dp and the top level.
package avcd_pkg;

   localparam int MAX_CHANNEL_LEN = 512;
   localparam int MAX_RESULTS     = 8;
   localparam int WIN_W           = 40;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_BYTE  = 2'd1,
      REQ_END   = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic load;
      logic step;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic go;
      logic go_next;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [31:0] value;
      logic [3:0]  run;
      logic [5:0]  len;
   } sym_type;

   // Look-ahead bits of each codec; zero marks a codec that decodes only zeros.
   function automatic logic [5:0] need_bits(input logic [5:0] cd);
      logic [5:0] nb;
      unique case (cd)
         6'd1: nb = 6'd2;   6'd2: nb = 6'd4;   6'd3: nb = 6'd3;   6'd4: nb = 6'd4;
         6'd5: nb = 6'd2;   6'd6: nb = 6'd3;   6'd7: nb = 6'd3;   6'd8: nb = 6'd5;
         6'd9: nb = 6'd4;   6'd10: nb = 6'd3;  6'd11: nb = 6'd5;  6'd12: nb = 6'd4;
         6'd13: nb = 6'd5;  6'd14: nb = 6'd6;  6'd15: nb = 6'd5;  6'd16: nb = 6'd7;
         6'd17: nb = 6'd7;  6'd18: nb = 6'd5;  6'd19: nb = 6'd6;  6'd20: nb = 6'd7;
         6'd21: nb = 6'd7;  6'd22: nb = 6'd6;  6'd23: nb = 6'd6;  6'd24: nb = 6'd6;
         6'd25: nb = 6'd6;  6'd26: nb = 6'd7;  6'd27: nb = 6'd9;  6'd28: nb = 6'd10;
         6'd29: nb = 6'd8;  6'd45: nb = 6'd5;  6'd46: nb = 6'd7;  6'd47: nb = 6'd7;
         6'd48: nb = 6'd7;  6'd49: nb = 6'd6;  6'd50: nb = 6'd8;  6'd51: nb = 6'd8;
         6'd52: nb = 6'd7;  6'd53: nb = 6'd8;  6'd54: nb = 6'd9;  6'd55: nb = 6'd10;
         6'd56: nb = 6'd11; 6'd57: nb = 6'd16; 6'd58: nb = 6'd24; 6'd59: nb = 6'd32;
         default: nb = 6'd0;
      endcase
      return nb;
   endfunction

   function automatic logic signed [63:0] adj7(input logic signed [63:0] v);
      return v[2] ? v : v - 64'sd7;
   endfunction

   function automatic logic signed [63:0] adj3(input logic signed [63:0] v);
      return v[1] ? v : v - 64'sd3;
   endfunction

   function automatic logic signed [63:0] shl(input logic signed [63:0] v,
                                              input logic signed [63:0] c);
      return v <<< c[4:0];
   endfunction

   function automatic sym_type mkv(input logic signed [63:0] x, input logic [5:0] l);
      sym_type r;
      r.value = x[31:0];
      r.run   = 4'd0;
      r.len   = l;
      return r;
   endfunction

   function automatic sym_type mkz(input logic [3:0] k, input logic [5:0] l);
      sym_type r;
      r.value = 32'd0;
      r.run   = k;
      r.len   = l;
      return r;
   endfunction

   // Decode one symbol from the low bits of the window.
   function automatic sym_type decode_sym(input logic [5:0] cd, input logic [31:0] w);
      logic [5:0]         nb;
      logic [63:0]        mask;
      logic signed [63:0] b;
      logic signed [63:0] v;
      logic signed [63:0] lo;
      nb   = need_bits(cd);
      mask = (64'd1 << nb) - 64'd1;
      b    = $signed({32'd0, w} & mask);
      v    = 64'sd0;
      lo   = 64'sd0;
      unique case (cd)
         6'd1: begin
            if (!b[0]) return mkv(0, 6'd1);
            return mkv((b & 3) - 2, 6'd2);
         end
         6'd2: begin
            if (!b[0]) return mkz(4'd7, 6'd1);
            if (!b[1]) return mkz(4'd2, 6'd2);
            if (!b[2]) return mkv(0, 6'd3);
            return mkv((b >>> 2) - 2, 6'd4);
         end
         6'd3: begin
            if (!b[0]) return mkz(4'd3, 6'd1);
            if (!b[1]) return mkv(0, 6'd2);
            return mkv((b >>> 1) - 2, 6'd3);
         end
         6'd4: begin
            if (!b[0]) return mkz(4'd4, 6'd1);
            if (!b[1]) return mkz(4'd2, 6'd2);
            if (!b[2]) return mkv(0, 6'd3);
            return mkv((b >>> 2) - 2, 6'd4);
         end
         6'd5: begin
            if ((b & 3) == 0) return mkz(4'd6, 6'd2);
            return mkv((b & 3) - 2, 6'd2);
         end
         6'd6: begin
            if (!b[0]) return mkv(0, 6'd1);
            v = b >>> 1;
            return mkv((v >>> 1) + v - 2, 6'd3);
         end
         6'd7: begin
            lo = b & 3;
            if (lo != 0) return mkv(lo - 2, 6'd2);
            return mkv(-64'sd2, 6'd3);
         end
         6'd8: begin
            if (!b[0]) return mkz(4'd4, 6'd1);
            if (!b[1]) return mkz(4'd2, 6'd2);
            if (!b[2]) return mkv(0, 6'd3);
            v = b >>> 3;
            return mkv((v >>> 1) + v - 2, 6'd5);
         end
         6'd9: begin
            lo = b & 3;
            if (lo != 0) return mkv(lo - 2, 6'd2);
            return mkv(adj3(b >>> 2), 6'd4);
         end
         6'd10: begin
            if ((b & 7) == 0) return mkz(4'd3, 6'd3);
            return mkv((b & 7) - 4, 6'd3);
         end
         6'd11: begin
            lo = b & 3;
            if (lo != 0) return mkv(lo - 2, 6'd2);
            v = b >>> 2;
            return mkv(v[2] ? v - 2 : v - 5, 6'd5);
         end
         6'd12: begin
            if ((b & 15) == 0) return mkz(4'd4, 6'd4);
            return mkv((b & 15) - 8, 6'd4);
         end
         6'd13: begin
            lo = b & 7;
            if (lo >= 3) return mkv(lo - 3, 6'd3);
            if (lo == 2) return mkv(b[3] ? 64'sd3 : -64'sd3, 6'd4);
            if (lo[0]) return mkv(-4 - (b >>> 3), 6'd5);
            return mkv((b >>> 3) + 4, 6'd5);
         end
         6'd14: begin
            lo = b & 3;
            if (lo != 0) return mkv(lo - 2, 6'd2);
            if (!b[2]) return mkv(adj3((b >>> 3) & 3), 6'd5);
            return mkv(adj7(b >>> 3), 6'd6);
         end
         6'd15: begin
            if (!b[0]) begin
               v = b & 15;
               if (v == 0) return mkz(4'd4, 6'd4);
               return mkv((v >>> 1) - 4, 6'd4);
            end
            return mkv(shl(adj7(b >>> 2), (b >>> 1) & 1), 6'd5);
         end
         6'd16: begin
            lo = b & 3;
            if (lo != 0) return mkv(lo - 2, 6'd2);
            if (!b[2]) return mkv(adj3((b >>> 3) & 3), 6'd5);
            return mkv(shl(adj7(b >>> 4), (b >>> 3) & 1), 6'd7);
         end
         6'd17, 6'd21, 6'd47, 6'd50: begin
            if (!b[0]) begin
               if (!b[1]) return mkz(4'd8, 6'd2);
               return mkv(0, 6'd2);
            end
            if (!b[1]) return mkv(((b >>> 1) & 2) - 1, 6'd3);
            if (cd == 6'd17) begin
               if (!b[2]) return mkv(adj3((b >>> 3) & 3), 6'd5);
               return mkv(shl(adj7(b >>> 4), (b >>> 3) & 1), 6'd7);
            end
            if (cd == 6'd21) begin
               if ((b & 12) == 0) return mkv(adj3((b >>> 4) & 3), 6'd6);
               return mkv(shl(adj7(b >>> 4), ((b >>> 2) & 3) - 1), 6'd7);
            end
            v = b >>> 2;
            if (cd == 6'd47) return mkv(v[4] ? v - 14 : v - 17, 6'd7);
            return mkv(v[5] ? v - 30 : v - 33, 6'd8);
         end
         6'd18: begin
            v = b & 31;
            if (v == 0) return mkz(4'd5, 6'd5);
            lo = v & 3;
            if (lo == 0) return mkv((v >>> 2) - 4, 6'd5);
            return mkv(shl(adj7(v >>> 2), lo - 1), 6'd5);
         end
         6'd19: begin
            if (!b[0]) begin
               v = b & 15;
               if (v == 0) return mkz(4'd4, 6'd4);
               return mkv((v >>> 1) - 4, 6'd4);
            end
            if (!b[1]) return mkv(adj7((b >>> 2) & 7), 6'd5);
            return mkv(shl(adj7(b >>> 3), ((b >>> 2) & 1) + 1), 6'd6);
         end
         6'd20: begin
            lo = b & 7;
            if (lo >= 3) return mkv(lo - 3, 6'd3);
            if (lo == 0) return mkv(b[3] ? 64'sd3 : -64'sd3, 6'd4);
            if (lo == 1) return mkv(adj7((b >>> 3) & 7), 6'd6);
            return mkv(shl(adj7(b >>> 4), ((b >>> 3) & 1) + 1), 6'd7);
         end
         6'd22: begin
            if (!b[0]) begin
               v = b & 15;
               if (v == 0) return mkz(4'd4, 6'd4);
               return mkv((v >>> 1) - 4, 6'd4);
            end
            return mkv(shl(adj7(b >>> 3), (b >>> 1) & 3), 6'd6);
         end
         6'd23, 6'd24, 6'd26: begin
            if (!b[0]) begin
               v = b & 31;
               if (v == 0) return mkz(4'd5, 6'd5);
               return mkv((v >>> 1) - 8, 6'd5);
            end
            if (cd == 6'd23) begin
               if (!b[1]) return mkv(shl(adj7((b >>> 2) & 7), 1), 6'd5);
               return mkv(shl(adj7(b >>> 3), ((b >>> 2) & 1) + 2), 6'd6);
            end
            if (cd == 6'd24) return mkv(shl(adj7(b >>> 3), ((b >>> 1) & 3) + 1), 6'd6);
            return mkv(shl(adj7(b >>> 4), ((b >>> 1) & 7) + 1), 6'd7);
         end
         6'd25, 6'd27, 6'd28: begin
            lo = b & 7;
            if (lo < 2) begin
               v = b & 31;
               if (v == 0) return mkz(4'd5, 6'd5);
               return mkv(v[0] ? (v >>> 3) : -(v >>> 3), 6'd5);
            end
            if (cd == 6'd25 || lo != 7) return mkv(shl(adj7((b >>> 3) & 7), lo - 2), 6'd6);
            if (cd == 6'd27) return mkv(shl(adj7(b >>> 6), ((b >>> 3) & 7) + 5), 6'd9);
            return mkv(shl(adj7(b >>> 7), ((b >>> 3) & 15) + 5), 6'd10);
         end
         6'd29: begin
            lo = b & 31;
            if (lo == 2) return mkv(0, 6'd5);
            if (lo < 2) return mkv(b[0] ? ((b >>> 5) & 3) + 1 : -1 - ((b >>> 5) & 3), 6'd7);
            return mkv(shl(adj7(b >>> 5), lo - 3), 6'd8);
         end
         6'd45: begin
            if (b == 0) return mkz(4'd5, 6'd5);
            return mkv(b - 16, 6'd5);
         end
         6'd46: begin
            if (!b[0]) return mkz(4'd4, 6'd1);
            if (!b[1]) return mkv(0, 6'd2);
            v = b >>> 2;
            return mkv((v >>> 4) + v - 16, 6'd7);
         end
         6'd48: begin
            lo = b & 3;
            if (lo != 0) return mkv(lo - 2, 6'd2);
            v = b >>> 2;
            return mkv(v[4] ? v - 14 : v - 17, 6'd7);
         end
         6'd49: begin
            if (b == 0) return mkz(4'd6, 6'd6);
            return mkv(b - 32, 6'd6);
         end
         6'd51: begin
            lo = b & 7;
            if (lo >= 3) return mkv(lo - 3, 6'd3);
            if (lo == 2) return mkv(b[3] ? 64'sd3 : -64'sd3, 6'd4);
            if (lo[0]) return mkv((b >>> 3) + 4, 6'd8);
            return mkv(-4 - (b >>> 3), 6'd8);
         end
         6'd52: begin
            if (b == 0) return mkz(4'd7, 6'd7);
            return mkv(b - 64, 6'd7);
         end
         6'd53: begin
            if (b == 0) return mkz(4'd8, 6'd8);
            return mkv(b - 128, 6'd8);
         end
         6'd54, 6'd55, 6'd56, 6'd57, 6'd58: begin
            if (b == 0) return mkz(4'd8, nb);
            return mkv(b - (64'sd1 <<< (nb - 6'd1)), nb);
         end
         6'd59: begin
            if (b == 64'sh80000000) return mkz(4'd8, 6'd32);
            return mkv(b, 6'd32);
         end
         default: return mkv(0, 6'd1);
      endcase
   endfunction

endpackage

// File: design/anim_channel_vlc_decoder_top.sv
// Animation channel delta decoder: decodes one channel of signed deltas from an
// LSB-first bitstream. A start request picks the codec and channel length, byte
// requests fill a 40-bit bit window, an end request pads the stream with zeros.
// Each result is a value with a repeat count; zero runs come out as value 0.
// Timing: a request is taken first, then the single shared symbol decoder
// produces one result per cycle while the result register is free, up to eight
// results per request.
// Requests are not taken while a request's results are still being produced.
// Depends on avcd_pkg, avcd_ctrl and avcd_dp.
module anim_channel_vlc_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [5:0]         req_codec_select,
   input  logic [9:0]         req_channel_length,
   input  logic [7:0]         req_stream_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_decoded_value,
   output logic [9:0]         rsp_repeat_count,
   output logic               rsp_channel_end,
   output logic               rsp_last
);
   import avcd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence requests and symbol steps.
   avcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the window and counts, decode symbols, register results.
   avcd_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_codec_select   (req_codec_select),
      .req_channel_length (req_channel_length),
      .req_stream_byte    (req_stream_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decoded_value  (rsp_decoded_value),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_channel_end    (rsp_channel_end),
      .rsp_last           (rsp_last)
   );
endmodule

// File: design/avcd_ctrl.sv
// Controller of the animation channel decoder: accepts requests, sequences symbols.
// Depends on avcd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module avcd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  avcd_pkg::status_type   status,
   output avcd_pkg::cmd_type      cmd
);
   import avcd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DECODE = 2'b10
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] count_ff, count_in;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = 3'd0;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.go) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.step = 1'b1;
               cmd.last = (count_ff == 3'(MAX_RESULTS - 1)) || !status.go_next;
               count_in = count_ff + 3'd1;
               if (cmd.last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   `AVCD_ASSERT(a_accept_decodes, clock, reset, (req_valid && !req_stall) |=> state_ff == ST_DECODE, "accepted request did not enter decode")
   `AVCD_ASSERT(a_last_idles, clock, reset, (cmd.step && cmd.last) |=> state_ff == ST_IDLE, "last result did not return to idle")
   `AVCD_NEVER(a_step_needs_room, clock, reset, cmd.step && !status.out_free, "symbol step with output register occupied")
endmodule

// File: design/avcd_dp.sv
// Datapath of the animation channel decoder: bit window, counts, symbol decode,
// result register. Depends on avcd_pkg.
module avcd_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_type,
   input  logic [5:0]             req_codec_select,
   input  logic [9:0]             req_channel_length,
   input  logic [7:0]             req_stream_byte,
   input  avcd_pkg::cmd_type      cmd,
   output avcd_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_decoded_value,
   output logic [9:0]             rsp_repeat_count,
   output logic                   rsp_channel_end,
   output logic                   rsp_last
);
   import avcd_pkg::*;

   logic [WIN_W-1:0] window_ff, window_in;
   logic [5:0]       held_ff, held_in;
   logic [9:0]       left_ff, left_in;
   logic [5:0]       codec_ff, codec_in;
   logic             ended_ff, ended_in;
   logic             valid_ff, valid_in;
   logic [31:0]      value_ff, value_in;
   logic [9:0]       count_ff, count_in;
   logic             end_ff, end_in;
   logic             last_ff, last_in;

   logic [5:0]       nb;
   sym_type          sym;
   logic [WIN_W-1:0] step_window;
   logic [5:0]       step_held;
   logic [9:0]       step_left;
   logic [9:0]       step_cnt;
   logic [31:0]      step_value;
   logic [9:0]       run_ext;

   assign nb  = need_bits(codec_ff);
   assign sym = decode_sym(codec_ff, window_ff[31:0]);
   assign run_ext = {6'd0, sym.run};

   // One symbol step on the current state.
   always_comb begin
      step_window = window_ff;
      step_held   = held_ff;
      step_left   = 10'd0;
      step_cnt    = left_ff;
      step_value  = (sym.run != 4'd0) ? 32'd0 : sym.value;
      if (nb == 6'd0) begin
         step_value = 32'd0;
      end else if (!(ended_ff && held_ff == 6'd0)) begin
         if (sym.len >= held_ff) begin
            step_window = '0;
            step_held   = 6'd0;
         end else begin
            step_window = window_ff >> sym.len;
            step_held   = held_ff - sym.len;
         end
         if (sym.run != 4'd0) begin
            step_cnt = (run_ext < left_ff) ? run_ext : left_ff;
         end else begin
            step_cnt = 10'd1;
         end
         step_left = left_ff - step_cnt;
      end
   end

   assign status.go       = (left_ff != 10'd0) &&
                            (nb == 6'd0 || held_ff >= nb || ended_ff);
   assign status.go_next  = (step_left != 10'd0) &&
                            (nb == 6'd0 || step_held >= nb || ended_ff);
   assign status.out_free = !valid_ff || !rsp_stall;

   always_comb begin
      window_in = window_ff;
      held_in   = held_ff;
      left_in   = left_ff;
      codec_in  = codec_ff;
      ended_in  = ended_ff;
      valid_in  = valid_ff && rsp_stall;
      value_in  = value_ff;
      count_in  = count_ff;
      end_in    = end_ff;
      last_in   = last_ff;
      if (cmd.load) begin
         unique case (req_kind_type'(req_type))
            REQ_START: begin
               codec_in = (req_codec_select >= 6'd32 && req_codec_select <= 6'd44) ?
                          req_codec_select - 6'd32 : req_codec_select;
               left_in  = (req_channel_length > 10'(MAX_CHANNEL_LEN)) ?
                          10'(MAX_CHANNEL_LEN) : req_channel_length;
            end
            REQ_BYTE: begin
               if (ended_ff) begin
                  if (req_stream_byte != 8'd0) begin
                     window_in = {32'd0, req_stream_byte};
                  end else begin
                     window_in = '0;
                  end
                  held_in  = 6'd8;
                  ended_in = 1'b0;
               end else if (held_ff <= 6'd32) begin
                  window_in = window_ff | ({32'd0, req_stream_byte} << held_ff);
                  held_in   = held_ff + 6'd8;
               end
            end
            REQ_END:  ended_in = 1'b1;
            REQ_NONE: ended_in = ended_ff;
            default:  ended_in = ended_ff;
         endcase
      end
      if (cmd.step) begin
         window_in = step_window;
         held_in   = step_held;
         left_in   = step_left;
         valid_in  = 1'b1;
         value_in  = step_value;
         count_in  = step_cnt;
         end_in    = (step_left == 10'd0);
         last_in   = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         held_ff   <= 6'd0;
         left_ff   <= 10'd0;
         codec_ff  <= 6'd0;
         ended_ff  <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         window_ff <= window_in;
         held_ff   <= held_in;
         left_ff   <= left_in;
         codec_ff  <= codec_in;
         ended_ff  <= ended_in;
         valid_ff  <= valid_in;
      end
      value_ff <= value_in;
      count_ff <= count_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_decoded_value = $signed(value_ff);
   assign rsp_repeat_count  = count_ff;
   assign rsp_channel_end   = end_ff;
   assign rsp_last          = last_ff;
endmodule
